[rtl/lswc_pkg.sv]
// lswc_pkg: shared widths, register codes and word types for the line clipper
// depends on nothing; used by every module of the clipper

package lswc_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIM_BITS   = 14;
   // internal coordinates also hold edges up to 2^DIM_BITS - 2
   localparam int CALC_BITS  = (COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1;
   localparam int DELTA_BITS = CALC_BITS + 1;
   localparam int QUO_BITS   = DELTA_BITS;
   localparam int PROD_BITS  = 2 * DELTA_BITS;
   localparam int MAX_MOVES  = 4;
   localparam int MOVE_BITS  = 3;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   localparam logic [3:0] OC_BOTTOM = 4'b1000;
   localparam logic [3:0] OC_TOP    = 4'b0100;
   localparam logic [3:0] OC_RIGHT  = 4'b0010;
   localparam logic [3:0] OC_LEFT   = 4'b0001;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_word_type;

   typedef struct packed {
      logic                         visible;
      logic signed [COORD_BITS-1:0] clipped_start_x;
      logic signed [COORD_BITS-1:0] clipped_start_y;
      logic signed [COORD_BITS-1:0] clipped_end_x;
      logic signed [COORD_BITS-1:0] clipped_end_y;
   } rsp_word_type;

   // word handed from one divider cell to the next
   typedef struct packed {
      logic                  valid;
      logic [DELTA_BITS-1:0] rem;
      logic [QUO_BITS-1:0]   low;
      logic [DELTA_BITS-1:0] divisor;
   } div_word_type;

endpackage

[rtl/lswc_div_cell.sv]
// lswc_div_cell: one restoring division step with a register on its output
// depends on lswc_pkg

module lswc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lswc_pkg::div_word_type cell_in,
   output lswc_pkg::div_word_type cell_out
);

   logic [lswc_pkg::DELTA_BITS:0] trial;
   logic [lswc_pkg::DELTA_BITS:0] diff;
   logic                          fits;
   lswc_pkg::div_word_type        word_in;
   lswc_pkg::div_word_type        word_ff;
   logic                          valid_ff;

   always_comb begin
      trial   = {cell_in.rem, cell_in.low[lswc_pkg::QUO_BITS-1]};
      diff    = trial - {1'b0, cell_in.divisor};
      fits    = (trial >= {1'b0, cell_in.divisor});
      word_in = cell_in;
      word_in.rem = fits ? diff[lswc_pkg::DELTA_BITS-1:0] : trial[lswc_pkg::DELTA_BITS-1:0];
      // dividend bits shift out the top, quotient bits shift in at the bottom
      word_in.low = {cell_in.low[lswc_pkg::QUO_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_comb begin
      cell_out       = word_ff;
      cell_out.valid = valid_ff;
   end

endmodule

[rtl/lswc_divider.sv]
// lswc_divider: row of division cells, one quotient bit per cell per cycle
// depends on lswc_pkg and lswc_div_cell

module lswc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lswc_pkg::div_word_type div_in,
   output lswc_pkg::div_word_type div_out
);

   lswc_pkg::div_word_type link [0:lswc_pkg::QUO_BITS];

   assign link[0] = div_in;

   genvar g;
   generate
      for (g = 0; g < lswc_pkg::QUO_BITS; g++) begin : g_cell
         lswc_div_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_in  (link[g]),
            .cell_out (link[g+1])
         );
      end
   endgenerate

   // after the last cell the low field holds the quotient
   assign div_out = link[lswc_pkg::QUO_BITS];

endmodule

[rtl/line_segment_window_clip.sv]
// line_segment_window_clip: outcode line clipper against a programmable window
// depends on lswc_pkg and lswc_divider
//
// One segment at a time. Each clip move passes the test, multiply and launch
// states and then waits while its word goes through the QUO_BITS (17) divider
// cells; the segment makes up to four moves. A finished word sits in the output
// register, and the next segment is taken as soon as the previous one reaches it.

module line_segment_window_clip (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lswc_pkg::req_word_type                  req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lswc_pkg::rsp_word_type                  rsp_data,
   input  logic                                   csr_write_en,
   input  logic [lswc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lswc_pkg::DIM_BITS-1:0]           csr_wdata
);

   localparam int CB = lswc_pkg::CALC_BITS;
   localparam int DB = lswc_pkg::DELTA_BITS;
   localparam int QB = lswc_pkg::QUO_BITS;
   localparam int PB = lswc_pkg::PROD_BITS;
   localparam int WB = lswc_pkg::COORD_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TEST   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_LAUNCH = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   function automatic logic [3:0] outcode(input logic signed [CB-1:0] x,
                                          input logic signed [CB-1:0] y,
                                          input logic signed [CB-1:0] xmax,
                                          input logic signed [CB-1:0] ymax);
      logic [3:0] c;
      c = 4'b0000;
      if (y > ymax) begin
         c = lswc_pkg::OC_BOTTOM;
      end else if (y < 0) begin
         c = lswc_pkg::OC_TOP;
      end
      if (x > xmax) begin
         c = c | lswc_pkg::OC_RIGHT;
      end else if (x < 0) begin
         c = c | lswc_pkg::OC_LEFT;
      end
      return c;
   endfunction

   function automatic logic [DB-1:0] magnitude(input logic signed [DB-1:0] v);
      return v[DB-1] ? DB'(-v) : DB'(v);
   endfunction

   logic [lswc_pkg::DIM_BITS-1:0] width_ff, height_ff;
   logic [2:0]                    state_ff, state_in;
   logic [lswc_pkg::MOVE_BITS-1:0] moves_ff;
   logic signed [CB-1:0]          x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [CB-1:0]          xmax, ymax;
   logic [3:0]                    c0, c1, oc;
   logic                          axis_y;
   logic signed [CB-1:0]          edge_sel, base_sel;
   logic signed [DB-1:0]          dx, dy, num_a, dist_b, span_d;
   logic [DB-1:0]                 a_mag_ff, b_mag_ff, d_mag_ff;
   logic                          neg_ff, axis_ff, side_ff, vis_ff;
   logic signed [CB-1:0]          edge_ff, base_ff;
   logic [PB-1:0]                 prod_ff;
   logic signed [QB:0]            quo_s, sum;
   logic signed [CB-1:0]          moved;
   lswc_pkg::div_word_type         div_in, div_out;
   lswc_pkg::rsp_word_type         rsp_data_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lswc_pkg::WIDTH_RESET;
         height_ff <= lswc_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lswc_pkg::CSR_CLIP_WIDTH:  width_ff  <= csr_wdata;
            lswc_pkg::CSR_CLIP_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign xmax = $signed(CB'(width_ff)) - $signed(CB'(1));
   assign ymax = $signed(CB'(height_ff)) - $signed(CB'(1));

   always_comb begin
      c0       = outcode(x0_ff, y0_ff, xmax, ymax);
      c1       = outcode(x1_ff, y1_ff, xmax, ymax);
      oc       = (c0 != 4'b0000) ? c0 : c1;
      axis_y   = |(oc & (lswc_pkg::OC_BOTTOM | lswc_pkg::OC_TOP));
      dx       = {x1_ff[CB-1], x1_ff} - {x0_ff[CB-1], x0_ff};
      dy       = {y1_ff[CB-1], y1_ff} - {y0_ff[CB-1], y0_ff};
      if (axis_y) begin
         edge_sel = |(oc & lswc_pkg::OC_BOTTOM) ? ymax : '0;
         base_sel = x0_ff;
         num_a    = dx;
         span_d   = dy;
         dist_b   = {edge_sel[CB-1], edge_sel} - {y0_ff[CB-1], y0_ff};
      end else begin
         edge_sel = |(oc & lswc_pkg::OC_RIGHT) ? xmax : '0;
         base_sel = y0_ff;
         num_a    = dy;
         span_d   = dx;
         dist_b   = {edge_sel[CB-1], edge_sel} - {x0_ff[CB-1], x0_ff};
      end
   end

   always_comb begin
      div_in.valid   = (state_ff == ST_LAUNCH);
      div_in.rem     = prod_ff[PB-1:QB];
      div_in.low     = prod_ff[QB-1:0];
      div_in.divisor = d_mag_ff;
   end

   lswc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   always_comb begin
      quo_s = neg_ff ? -$signed({1'b0, div_out.low}) : $signed({1'b0, div_out.low});
      sum   = $signed({{(QB + 1 - CB){base_ff[CB-1]}}, base_ff}) + quo_s;
      moved = sum[CB-1:0];
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_TEST;
         end
         ST_TEST: begin
            if ((c0 == 4'b0000 && c1 == 4'b0000) || (c0 & c1) != 4'b0000 ||
                moves_ff == lswc_pkg::MOVE_BITS'(lswc_pkg::MAX_MOVES) ||
                span_d == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_DIV;
         ST_DIV: begin
            if (div_out.valid) state_in = ST_TEST;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         moves_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            moves_ff <= '0;
         end else if (state_ff == ST_DIV && div_out.valid) begin
            moves_ff <= moves_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            x0_ff  <= CB'(req_data.start_x);
            y0_ff  <= CB'(req_data.start_y);
            x1_ff  <= CB'(req_data.end_x);
            y1_ff  <= CB'(req_data.end_y);
            vis_ff <= 1'b0;
         end
         ST_TEST: begin
            vis_ff   <= (c0 == 4'b0000) && (c1 == 4'b0000);
            a_mag_ff <= magnitude(num_a);
            b_mag_ff <= magnitude(dist_b);
            d_mag_ff <= magnitude(span_d);
            neg_ff   <= num_a[DB-1] ^ dist_b[DB-1] ^ span_d[DB-1];
            edge_ff  <= edge_sel;
            base_ff  <= base_sel;
            axis_ff  <= axis_y;
            side_ff  <= (c0 == 4'b0000);
         end
         ST_MUL: begin
            prod_ff <= PB'(a_mag_ff) * PB'(b_mag_ff);
         end
         ST_DIV: begin
            if (div_out.valid) begin
               if (!side_ff) begin
                  x0_ff <= axis_ff ? moved : edge_ff;
                  y0_ff <= axis_ff ? edge_ff : moved;
               end else begin
                  x1_ff <= axis_ff ? moved : edge_ff;
                  y1_ff <= axis_ff ? edge_ff : moved;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.visible         <= vis_ff;
         rsp_data_ff.clipped_start_x <= x0_ff[WB-1:0];
         rsp_data_ff.clipped_start_y <= y0_ff[WB-1:0];
         rsp_data_ff.clipped_end_x   <= x1_ff[WB-1:0];
         rsp_data_ff.clipped_end_y   <= y1_ff[WB-1:0];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> state_ff == ST_DIV)
      else $error("divider word came out outside the wait state");

   a_move_limit: assert property (@(posedge clock) disable iff (reset)
      moves_ff <= lswc_pkg::MOVE_BITS'(lswc_pkg::MAX_MOVES))
      else $error("clip move count passed its limit");

   a_visible_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && vis_ff) |-> (c0 == 4'b0000 && c1 == 4'b0000))
      else $error("segment marked visible with an endpoint outside");

endmodule
